@@ hw/rtl/fvsc_pkg.sv @@
package fvsc_pkg;

    localparam logic [7:0] MSG_LEN    = 8'd163;
    localparam logic [7:0] DATA_FIRST = 8'd6;
    localparam logic [7:0] DATA_END   = 8'd161;
    localparam logic [7:0] CSUM_POS   = 8'd161;
    localparam logic [7:0] END_POS    = 8'd162;
    localparam logic [7:0] FINAL_IDX  = 8'd155;

    localparam logic [7:0] START_BYTE  = 8'hF0;
    localparam logic [7:0] END_BYTE    = 8'hF7;
    localparam logic [7:0] MAKER_ID    = 8'h43;
    localparam logic [7:0] FORMAT_BYTE = 8'h00;
    localparam logic [7:0] COUNT_MSB   = 8'h01;
    localparam logic [7:0] COUNT_LSB   = 8'h1B;
    localparam logic [7:0] FINAL_BYTE  = 8'h3F;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FRAME    = 3'd1,
        ST_LENGTH   = 3'd2,
        ST_HEADER   = 3'd3,
        ST_CHECKSUM = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0] patch_index;
        logic [7:0] patch_byte;
        logic       message_done;
        status_t    status;
    } result_t;

endpackage

@@ hw/rtl/fvsc_parser.sv @@
module fvsc_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output logic              res_valid,
    output fvsc_pkg::result_t res
);
    import fvsc_pkg::*;

    logic [7:0] byte_position_reg, byte_position_next;
    logic [6:0] negated_sum_reg, negated_sum_next;
    logic       frame_bad_reg, frame_bad_next;
    logic       header_bad_reg, header_bad_next;
    logic       checksum_bad_reg, checksum_bad_next;
    logic       header_miss;
    logic [7:0] pos;

    assign pos = byte_position_reg;

    always_comb
    begin
        case (pos)
            8'd1:    header_miss = (data_byte != MAKER_ID);
            8'd2:    header_miss = (data_byte[7:4] != 4'h0);
            8'd3:    header_miss = (data_byte != FORMAT_BYTE);
            8'd4:    header_miss = (data_byte != COUNT_MSB);
            8'd5:    header_miss = (data_byte != COUNT_LSB);
            default: header_miss = 1'b0;
        endcase
    end

    always_comb
    begin
        byte_position_next = byte_position_reg;
        negated_sum_next   = negated_sum_reg;
        frame_bad_next     = frame_bad_reg;
        header_bad_next    = header_bad_reg;
        checksum_bad_next  = checksum_bad_reg;
        res_valid          = 1'b0;
        res.patch_index    = pos - DATA_FIRST;
        res.patch_byte     = data_byte;
        res.message_done   = 1'b0;
        res.status         = ST_OK;

        if (last_byte)
        begin
            res_valid        = 1'b1;
            res.patch_index  = FINAL_IDX;
            res.patch_byte   = FINAL_BYTE;
            res.message_done = 1'b1;
            if (pos != END_POS)
                res.status = ST_LENGTH;
            else if (frame_bad_reg || data_byte != END_BYTE)
                res.status = ST_FRAME;
            else if (header_bad_reg)
                res.status = ST_HEADER;
            else if (checksum_bad_reg)
                res.status = ST_CHECKSUM;
            else
                res.status = ST_OK;
            byte_position_next = '0;
            negated_sum_next   = '0;
            frame_bad_next     = 1'b0;
            header_bad_next    = 1'b0;
            checksum_bad_next  = 1'b0;
        end
        else
        begin
            if (pos < MSG_LEN)
                byte_position_next = pos + 8'd1;
            if (pos == 8'd0)
            begin
                if (data_byte != START_BYTE)
                    frame_bad_next = 1'b1;
            end
            else if (pos < DATA_FIRST)
            begin
                if (header_miss)
                    header_bad_next = 1'b1;
            end
            else if (pos < DATA_END)
            begin
                negated_sum_next = negated_sum_reg - data_byte[6:0];
                res_valid        = 1'b1;
            end
            else if (pos == CSUM_POS)
            begin
                if (data_byte != {1'b0, negated_sum_reg})
                    checksum_bad_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg <= '0;
            negated_sum_reg   <= '0;
            frame_bad_reg     <= 1'b0;
            header_bad_reg    <= 1'b0;
            checksum_bad_reg  <= 1'b0;
        end
        else if (accept)
        begin
            byte_position_reg <= byte_position_next;
            negated_sum_reg   <= negated_sum_next;
            frame_bad_reg     <= frame_bad_next;
            header_bad_reg    <= header_bad_next;
            checksum_bad_reg  <= checksum_bad_next;
        end
    end

endmodule

@@ hw/rtl/fvsc_out_buf.sv @@
module fvsc_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  fvsc_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output fvsc_pkg::result_t out_data
);
    import fvsc_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (push)
                out_data_reg <= push_data;
        end
        else if (push)
        begin
            skid_data_reg <= push_data;
        end
    end

endmodule

@@ hw/rtl/fm_voice_sysex_checker.sv @@
// Checks one 163-byte single-voice FM patch system-exclusive message.
// The input channel (in_valid, in_stall, data_byte, last_byte) takes one
// message byte per transaction, with last_byte set on the final byte.
// The output channel (out_valid, out_stall, patch_index, patch_byte,
// message_done, status) gives one transaction per data byte, with indexes
// 0 to 154, and one final transaction with index 155, byte 0x3F,
// message_done set and the message status.
// Start, header and checksum bytes give no output transaction; the end byte gives only the final one.
// The consumer keeps the streamed bytes only if the final status is ok.
// A result is registered in the output buffer before it reaches the output,
// and one byte is taken in every cycle while in_stall is low.
// The rate is set by the byte position and checksum registers, which are
// updated once per accepted byte.
// A two-entry output buffer lets bytes keep flowing while one result
// waits; in_stall rises only when both entries are full.
// Reset clears the byte position, the running checksum, the error flags
// and the valid flags of both output entries.
module fm_voice_sysex_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] patch_index,
    output logic [7:0] patch_byte,
    output logic       message_done,
    output logic [2:0] status
);
    import fvsc_pkg::*;

    logic    accept;
    logic    res_valid;
    result_t res;
    logic    buf_full;
    result_t out_data;

    assign in_stall = buf_full;
    assign accept   = in_valid && !buf_full;

    fvsc_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    fvsc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && res_valid),
        .push_data (res),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign patch_index  = out_data.patch_index;
    assign patch_byte   = out_data.patch_byte;
    assign message_done = out_data.message_done;
    assign status       = out_data.status;

endmodule

@@ hw/rtl/fvsc_checker.sv @@
module fvsc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] patch_index,
    input logic [7:0] patch_byte,
    input logic       message_done,
    input logic [2:0] status
);
    import fvsc_pkg::*;

    a_final_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && message_done |-> patch_index == FINAL_IDX && patch_byte == FINAL_BYTE)
        else $error("Final transaction has wrong index or byte.");

    a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !message_done |-> status == ST_OK && patch_index < FINAL_IDX)
        else $error("Data transaction has bad status or index.");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_CHECKSUM)
        else $error("Status code out of range.");

    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("Input stalled with no result pending.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(patch_index) && $stable(patch_byte)
            && $stable(message_done) && $stable(status))
        else $error("Stalled output transaction changed.");

endmodule

bind fm_voice_sysex_checker fvsc_checker u_fvsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .patch_index  (patch_index),
    .patch_byte   (patch_byte),
    .message_done (message_done),
    .status       (status)
);

@@ test/fvsc_result_checker.sv @@
`timescale 1ns / 1ps

module fvsc_result_checker
    import fvsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] patch_index,
    input  logic [7:0] patch_byte,
    input  logic       message_done,
    input  logic [2:0] status,
    output int         mismatches,
    output int         expect_left,
    output int         results_compared,
    output int         messages_done,
    output int         messages_ok
);

    localparam logic [7:0] POS_MAKER     = 8'd1;
    localparam logic [7:0] POS_CHANNEL   = 8'd2;
    localparam logic [7:0] POS_FORMAT    = 8'd3;
    localparam logic [7:0] POS_COUNT_MSB = 8'd4;
    localparam logic [7:0] POS_COUNT_LSB = 8'd5;

    logic [7:0] position;
    logic [6:0] running_sum;
    logic       frame_err;
    logic       header_err;
    logic       sum_err;

    result_t pending_results[$];

    initial
    begin
        mismatches = 0;
        expect_left = 0;
        results_compared = 0;
        messages_done = 0;
        messages_ok = 0;
        position = '0;
        running_sum = '0;
        frame_err = 1'b0;
        header_err = 1'b0;
        sum_err = 1'b0;
    end

    function automatic bit predict_patch_result(input logic [7:0] b, input logic last,
                                                output result_t r);
        logic [7:0] cur;
        cur = position;
        r.patch_index = '0;
        r.patch_byte = '0;
        r.message_done = 1'b0;
        r.status = ST_OK;
        if (last)
        begin
            r.patch_index = FINAL_IDX;
            r.patch_byte = FINAL_BYTE;
            r.message_done = 1'b1;
            if (cur != END_POS)
                r.status = ST_LENGTH;
            else if (frame_err || b != END_BYTE)
                r.status = ST_FRAME;
            else if (header_err)
                r.status = ST_HEADER;
            else if (sum_err)
                r.status = ST_CHECKSUM;
            else
                r.status = ST_OK;
            position = '0;
            running_sum = '0;
            frame_err = 1'b0;
            header_err = 1'b0;
            sum_err = 1'b0;
            return 1'b1;
        end
        if (cur < MSG_LEN)
            position = cur + 8'd1;
        if (cur == 8'd0)
        begin
            if (b != START_BYTE)
                frame_err = 1'b1;
            return 1'b0;
        end
        if (cur < DATA_FIRST)
        begin
            if (cur == POS_MAKER && b != MAKER_ID)
                header_err = 1'b1;
            if (cur == POS_CHANNEL && b[7:4] != 4'h0)
                header_err = 1'b1;
            if (cur == POS_FORMAT && b != FORMAT_BYTE)
                header_err = 1'b1;
            if (cur == POS_COUNT_MSB && b != COUNT_MSB)
                header_err = 1'b1;
            if (cur == POS_COUNT_LSB && b != COUNT_LSB)
                header_err = 1'b1;
            return 1'b0;
        end
        if (cur < DATA_END)
        begin
            running_sum = running_sum - b[6:0];
            r.patch_index = cur - DATA_FIRST;
            r.patch_byte = b;
            return 1'b1;
        end
        if (cur == CSUM_POS && b != {1'b0, running_sum})
            sum_err = 1'b1;
        return 1'b0;
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected transaction: index %0d byte %h done %b status %0d",
                                 $time, patch_index, patch_byte, message_done, status);
                end
                else
                begin
                    want = pending_results.pop_front();
                    results_compared++;
                    if (want.message_done)
                    begin
                        messages_done++;
                        if (want.status == ST_OK)
                            messages_ok++;
                    end
                    if (patch_index !== want.patch_index || patch_byte !== want.patch_byte ||
                        message_done !== want.message_done || status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch: expected index %0d byte %h done %b ",
                                      "status %0d, got index %0d byte %h done %b status %0d"},
                                     $time, want.patch_index, want.patch_byte,
                                     want.message_done, want.status, patch_index,
                                     patch_byte, message_done, status);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (predict_patch_result(data_byte, last_byte, got))
                    pending_results.push_back(got);
            end
        end
        expect_left = pending_results.size();
    end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import fvsc_pkg::*;

    localparam int CHANNEL_POS = 2;
    localparam int PHASE_BYTES = 175;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] patch_index;
    logic [7:0] patch_byte;
    logic       message_done;
    logic [2:0] status;

    int mismatches;
    int expect_left;
    int results_compared;
    int messages_done;
    int messages_ok;

    int send_idle;
    int recv_idle;
    int bytes_sent;
    int messages_sent;

    fm_voice_sysex_checker uut (.*);

    fvsc_result_checker result_check (.*);

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_idle);

    initial
    begin
        #2_000_000;
        $display("Run timed out.");
        $display("CHECK FAILED");
        $finish;
    end

    task automatic put_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
        if (last)
            messages_sent++;
        @(negedge clk);
    endtask

    task automatic send_message(input int len, input bit bad_start, input bit bad_head,
                                input bit bad_sum, input bit bad_end, input bit noise);
        logic [7:0] head[6];
        logic [6:0] sum;
        logic [7:0] b;
        logic [7:0] flip;
        int k;
        int p;
        head[0] = START_BYTE;
        head[1] = MAKER_ID;
        head[2] = {4'h0, 4'($urandom_range(15))};
        head[3] = FORMAT_BYTE;
        head[4] = COUNT_MSB;
        head[5] = COUNT_LSB;
        if (bad_start)
            head[0] = head[0] ^ 8'($urandom_range(1, 255));
        if (bad_head)
        begin
            p = $urandom_range(1, 5);
            if (p == CHANNEL_POS)
                head[p][7:4] = 4'($urandom_range(1, 15));
            else
                head[p] = head[p] ^ 8'($urandom_range(1, 255));
        end
        sum = '0;
        for (k = 0; k < len - 1; k++)
        begin
            if (noise)
                b = 8'($urandom_range(255));
            else if (k < DATA_FIRST)
                b = head[k];
            else if (k < DATA_END)
            begin
                b = 8'($urandom_range(255));
                sum = sum - b[6:0];
            end
            else if (k == CSUM_POS)
            begin
                flip = 8'h01 << $urandom_range(7);
                b = {1'b0, sum} ^ (bad_sum ? flip : 8'h00);
            end
            else
                b = $urandom_range(1) ? END_BYTE : 8'($urandom_range(255));
            put_byte(b, 1'b0);
        end
        if (noise)
            b = 8'($urandom_range(255));
        else if (bad_end)
            b = END_BYTE ^ 8'($urandom_range(1, 255));
        else
            b = END_BYTE;
        put_byte(b, 1'b1);
    endtask

    initial
    begin
        int send_pct[3];
        int recv_pct[3];
        int phase;
        int phase_start;
        int r;
        int len;
        int k;
        bit first;
        bit clean;
        send_pct = '{12, 58, 0};
        recv_pct = '{58, 12, 0};
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        out_stall = 1'b0;
        send_idle = send_pct[0];
        recv_idle = recv_pct[0];
        bytes_sent = 0;
        messages_sent = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Short messages: end flag at the start, in the header and in the data range.
        put_byte(END_BYTE, 1'b1);
        put_byte(8'h00, 1'b1);
        put_byte(START_BYTE, 1'b0);
        put_byte(8'hFF, 1'b1);
        put_byte(START_BYTE, 1'b0);
        put_byte(MAKER_ID, 1'b0);
        put_byte(8'h0F, 1'b0);
        put_byte(FORMAT_BYTE, 1'b0);
        put_byte(COUNT_MSB, 1'b0);
        put_byte(COUNT_LSB, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h7F, 1'b0);
        put_byte(8'h80, 1'b0);
        put_byte(8'h55, 1'b1);
        put_byte(8'hFF, 1'b0);
        put_byte(MAKER_ID, 1'b0);
        put_byte(FINAL_BYTE, 1'b1);

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle = send_pct[phase];
            recv_idle = recv_pct[phase];
            phase_start = bytes_sent;
            first = 1'b1;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                r = $urandom_range(99);
                if (!first)
                    len = $urandom_range(1, PHASE_BYTES - (bytes_sent - phase_start));
                else if (phase == 0)
                    len = MSG_LEN;
                else if (phase == 1)
                    len = MSG_LEN + $urandom_range(1, 4);
                else
                    len = $urandom_range(150, MSG_LEN);
                clean = first && phase == 0;
                send_message(len, !clean && $urandom_range(99) < 12,
                             !clean && $urandom_range(99) < 20,
                             !clean && $urandom_range(99) < 25,
                             !clean && $urandom_range(99) < 12,
                             !first && r >= 80);
                first = 1'b0;
            end
        end
        in_valid <= 1'b0;

        k = 0;
        while (expect_left != 0 && k < 5000)
        begin
            @(negedge clk);
            k++;
        end
        repeat (8) @(negedge clk);

        if (expect_left != 0)
            $display("%0d expected results never arrived.", expect_left);
        $display("Sent %0d bytes in %0d messages under three idle mixes.",
                 bytes_sent, messages_sent);
        $display("Compared %0d results; %0d of %0d finished messages had ok status.",
                 results_compared, messages_ok, messages_done);
        if (mismatches == 0 && expect_left == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
